@@ design/assert_macros.svh @@
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication under reset.
`define ASSERT_NOW(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication under reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

@@ design/bdle_pkg.sv @@
// Types and codes of the bounded list engine.
package bdle_pkg;
	localparam int unsigned CNT_W = 7;

	localparam logic [3:0] MODE_ADD_HEAD = 4'd0;
	localparam logic [3:0] MODE_ADD_TAIL = 4'd1;
	localparam logic [3:0] MODE_DUMP     = 4'd2;
	localparam logic [3:0] MODE_DUMP_REV = 4'd3;
	localparam logic [3:0] MODE_SEARCH   = 4'd4;
	localparam logic [3:0] MODE_DEL_HEAD = 4'd5;
	localparam logic [3:0] MODE_DEL_TAIL = 4'd6;
	localparam logic [3:0] MODE_DEL_POS  = 4'd7;
	localparam logic [3:0] MODE_DEL_VAL  = 4'd8;
	localparam logic [3:0] MODE_INS_POS  = 4'd9;

	localparam logic [2:0] ST_DONE      = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_BAD_POS   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_FOUND     = 3'd5;

	typedef struct packed {
		logic [3:0]         mode;
		logic signed [31:0] item_value;
		logic [5:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] element_value;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROTF,
		CELL_ROTB
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [CNT_W-1:0]   idx;
		logic [CNT_W-1:0]   count;
		logic [31:0]        value;
	} cell_cmd_t;
endpackage

@@ design/bdle_stream_if.sv @@
// Valid/ready stream interface carrying one payload type.
interface bdle_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/bdle_cell.sv @@
// One list cell holding one element and trading it with its neighbors.
module bdle_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic                  clk,
	input  bdle_pkg::cell_cmd_t   cmd,
	input  logic [31:0]           left,
	input  logic [31:0]           right,
	input  logic [31:0]           head,
	input  logic [31:0]           tail,
	output logic [31:0]           q
);
	localparam logic [bdle_pkg::CNT_W-1:0] IDX = bdle_pkg::CNT_W'(INDEX);
	localparam logic [bdle_pkg::CNT_W-1:0] IDX1 = bdle_pkg::CNT_W'(INDEX + 1);

	logic [31:0] elem_q;
	logic [31:0] nxt;

	always_comb begin
		nxt = elem_q;
		case (cmd.op)
			bdle_pkg::CELL_INS: begin
				if (IDX == cmd.idx) nxt = cmd.value;
				else if (IDX > cmd.idx) nxt = left;
			end
			bdle_pkg::CELL_DEL: begin
				if (IDX >= cmd.idx) nxt = right;
			end
			bdle_pkg::CELL_ROTF: begin
				if (IDX1 == cmd.count) nxt = head;
				else if (IDX1 < cmd.count) nxt = right;
			end
			bdle_pkg::CELL_ROTB: begin
				if (IDX == '0) nxt = tail;
				else if (IDX < cmd.count) nxt = left;
			end
			default: nxt = elem_q;
		endcase
	end

	always_ff @(posedge clk) begin
		elem_q <= nxt;
	end

	assign q = elem_q;
endmodule

@@ design/bounded_double_ended_list_engine_core.sv @@
// Top level of the bounded list engine: control and a chain of element cells.
//
//   channel  dir  payload
//   req      in   mode, item_value, position
//   rsp      out  status, element_value, last
//
// Inserts, deletes and rejected requests are answered straight from the idle state.
// Dump, search and delete by value rotate the chain once around, one cell a
// cycle while the output is free; a delete by value then drops its match.
// A new request is taken only when no walk is running and the output
// register is free or being emptied; a stalled output pauses the walk.
// Reset clears the element count; the cells hold no reset.
module bounded_double_ended_list_engine_core #(
	parameter int unsigned CAPACITY = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bdle_stream_if.sink                          req,
	bdle_stream_if.source                        rsp
);
	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [bdle_pkg::CNT_W-1:0] CAP = bdle_pkg::CNT_W'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_WALK = 3'b010,
		S_DEL  = 3'b100
	} state_t;

	state_t                          state_q;
	logic [3:0]                      mode_q;
	logic [31:0]                     val_q;
	logic [bdle_pkg::CNT_W-1:0]      k_q;
	logic [bdle_pkg::CNT_W-1:0]      fidx_q;
	logic                            found_q;
	logic [bdle_pkg::CNT_W-1:0]      count_q;
	logic                            ov_q;
	bdle_pkg::rsp_t                  od_q;

	bdle_pkg::cell_cmd_t             cmd;
	logic [31:0]                     cells [CAPACITY];
	logic [31:0]                     head;
	logic [31:0]                     tail;
	logic [bdle_pkg::CNT_W-1:0]      cnt_m1;
	logic [bdle_pkg::CNT_W-1:0]      pos_ext;
	logic [bdle_pkg::CNT_W-1:0]      pos_m1;
	logic                            ov_free;
	logic                            accept;
	logic                            full;
	logic                            empty;
	logic                            match;
	logic                            last_step;

	assign ov_free   = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && ov_free;
	assign accept    = req.valid && req.ready;
	assign rsp.valid = ov_q;
	assign rsp.data  = od_q;

	assign cnt_m1    = count_q - 1'b1;
	assign pos_ext   = bdle_pkg::CNT_W'(req.data.position);
	assign pos_m1    = pos_ext - 1'b1;
	assign full      = count_q >= CAP;
	assign empty     = count_q == '0;
	assign head      = cells[0];
	assign tail      = cells[cnt_m1[AW-1:0]];
	assign match     = head == val_q;
	assign last_step = k_q == cnt_m1;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [31:0] lft;
			logic [31:0] rgt;
			if (gi == 0) begin : g_first
				assign lft = cells[gi];
			end else begin : g_mid_l
				assign lft = cells[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign rgt = cells[gi];
			end else begin : g_mid_r
				assign rgt = cells[gi+1];
			end
			bdle_cell #(.INDEX(gi)) u_cell (
				.clk   (clk),
				.cmd   (cmd),
				.left  (lft),
				.right (rgt),
				.head  (head),
				.tail  (tail),
				.q     (cells[gi])
			);
		end
	endgenerate

	always_comb begin
		cmd.op    = bdle_pkg::CELL_HOLD;
		cmd.idx   = '0;
		cmd.count = count_q;
		cmd.value = req.data.item_value;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.data.mode)
						bdle_pkg::MODE_ADD_HEAD: if (!full) cmd.op = bdle_pkg::CELL_INS;
						bdle_pkg::MODE_ADD_TAIL: begin
							if (!full) cmd.op = bdle_pkg::CELL_INS;
							cmd.idx = count_q;
						end
						bdle_pkg::MODE_INS_POS: begin
							if (!full && pos_ext != '0 && pos_ext <= count_q)
								cmd.op = bdle_pkg::CELL_INS;
							else if (!full && pos_ext != '0 && pos_m1 == count_q)
								cmd.op = bdle_pkg::CELL_INS;
							cmd.idx = pos_m1;
						end
						bdle_pkg::MODE_DEL_HEAD: if (!empty) cmd.op = bdle_pkg::CELL_DEL;
						bdle_pkg::MODE_DEL_TAIL: begin
							if (!empty) cmd.op = bdle_pkg::CELL_DEL;
							cmd.idx = cnt_m1;
						end
						bdle_pkg::MODE_DEL_POS: begin
							if (pos_ext != '0 && pos_ext <= count_q) cmd.op = bdle_pkg::CELL_DEL;
							cmd.idx = pos_m1;
						end
						default: cmd.op = bdle_pkg::CELL_HOLD;
					endcase
				end
			end
			S_WALK: begin
				if (ov_free) begin
					cmd.op = (mode_q == bdle_pkg::MODE_DUMP_REV) ?
						bdle_pkg::CELL_ROTB : bdle_pkg::CELL_ROTF;
				end
			end
			S_DEL: begin
				if (ov_free) cmd.op = bdle_pkg::CELL_DEL;
				cmd.idx = fidx_q;
			end
			default: cmd.op = bdle_pkg::CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ov_q    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (rsp.ready) ov_q <= 1'b0;
			case (cmd.op)
				bdle_pkg::CELL_INS: count_q <= count_q + 1'b1;
				bdle_pkg::CELL_DEL: count_q <= cnt_m1;
				default: count_q <= count_q;
			endcase
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q  <= req.data.mode;
						val_q   <= req.data.item_value;
						k_q     <= '0;
						found_q <= 1'b0;
						ov_q    <= 1'b1;
						od_q    <= '{status: bdle_pkg::ST_DONE, element_value: '0, last: 1'b1};
						case (req.data.mode)
							bdle_pkg::MODE_ADD_HEAD, bdle_pkg::MODE_ADD_TAIL: begin
								if (full) od_q.status <= bdle_pkg::ST_FULL;
							end
							bdle_pkg::MODE_INS_POS: begin
								if (full) od_q.status <= bdle_pkg::ST_FULL;
								else if (pos_ext == '0 || pos_m1 > count_q)
									od_q.status <= bdle_pkg::ST_BAD_POS;
							end
							bdle_pkg::MODE_DEL_HEAD, bdle_pkg::MODE_DEL_TAIL: begin
								if (empty) od_q.status <= bdle_pkg::ST_EMPTY;
							end
							bdle_pkg::MODE_DEL_POS: begin
								if (pos_ext == '0 || pos_ext > count_q)
									od_q.status <= bdle_pkg::ST_BAD_POS;
							end
							bdle_pkg::MODE_DUMP, bdle_pkg::MODE_DUMP_REV,
							bdle_pkg::MODE_SEARCH, bdle_pkg::MODE_DEL_VAL: begin
								if (empty) begin
									od_q.status <= bdle_pkg::ST_EMPTY;
								end else begin
									ov_q    <= 1'b0;
									state_q <= S_WALK;
								end
							end
							default: od_q.status <= bdle_pkg::ST_DONE;
						endcase
					end
				end
				S_WALK: begin
					if (ov_free) begin
						k_q <= k_q + 1'b1;
						if (match && !found_q) begin
							found_q <= 1'b1;
							fidx_q  <= k_q;
						end
						if (mode_q == bdle_pkg::MODE_DUMP || mode_q == bdle_pkg::MODE_DUMP_REV) begin
							ov_q <= 1'b1;
							od_q <= '{status: bdle_pkg::ST_DONE,
								element_value: (mode_q == bdle_pkg::MODE_DUMP) ? head : tail,
								last: last_step};
							if (last_step) state_q <= S_IDLE;
						end else if (last_step) begin
							if (mode_q == bdle_pkg::MODE_DEL_VAL && (found_q || match)) begin
								state_q <= S_DEL;
							end else begin
								ov_q    <= 1'b1;
								od_q    <= '{status: (found_q || match) ? bdle_pkg::ST_FOUND :
									bdle_pkg::ST_NOT_FOUND, element_value: '0, last: 1'b1};
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_DEL: begin
					if (ov_free) begin
						ov_q    <= 1'b1;
						od_q    <= '{status: bdle_pkg::ST_DONE, element_value: '0, last: 1'b1};
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/bdle_checker.sv @@
// Port-level checker for the bounded list engine, bound to the top level.
`include "assert_macros.svh"
module bdle_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [2:0]  rsp_status,
	input logic [31:0] rsp_value,
	input logic        rsp_last
);
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_NOW(a_accept_free, clk, arst_n, req_valid && req_ready, !rsp_valid || rsp_ready)
	`ASSERT_NOW(a_value_done, clk, arst_n, rsp_valid && rsp_value != 32'd0, rsp_status == bdle_pkg::ST_DONE)
	`ASSERT_NOW(a_status_last, clk, arst_n, rsp_valid && rsp_status != bdle_pkg::ST_DONE, rsp_last)
endmodule

bind bounded_double_ended_list_engine_core bdle_checker u_bdle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.data.status),
	.rsp_value  (rsp.data.element_value),
	.rsp_last   (rsp.data.last)
);

@@ tb/bounded_double_ended_list_engine_core_tb.sv @@
// Self-checking testbench for the bounded list engine: directed table, then random requests.
module bounded_double_ended_list_engine_core_tb;
	localparam int unsigned CAP = 32;

	logic clk;
	logic arst_n;

	bdle_stream_if #(.T(bdle_pkg::req_t)) req_ch ();
	bdle_stream_if #(.T(bdle_pkg::rsp_t)) rsp_ch ();

	bounded_double_ended_list_engine_core #(.CAPACITY(CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	typedef struct {
		bdle_pkg::req_t r;
		bit             typed;
		bdle_pkg::rsp_t want;
	} row_t;

	logic signed [31:0] list_mirror[$];
	bdle_pkg::rsp_t     pending_rsp[$];
	int                 error_count = 0;
	bit                 stim_done = 0;
	bit                 hold_long = 0;
	row_t               directed[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("bounded_double_ended_list_engine_core_tb: errors");
		$finish;
	end

	task automatic report(input string what);
		$display("mismatch: %s", what);
		error_count++;
	endtask

	function automatic bdle_pkg::rsp_t mk(input logic [2:0] st, input logic signed [31:0] v,
			input logic lst);
		bdle_pkg::rsp_t x;
		x.status = st;
		x.element_value = v;
		x.last = lst;
		return x;
	endfunction

	// Applies one request to the mirror list and queues what it should answer.
	task automatic apply_request(input bdle_pkg::req_t r);
		logic [2:0] st;
		int n;
		int hit;
		st = bdle_pkg::ST_DONE;
		n = list_mirror.size();
		hit = -1;
		for (int i = 0; i < n; i++)
			if (hit < 0 && list_mirror[i] == r.item_value)
				hit = i;
		case (r.mode)
			bdle_pkg::MODE_ADD_HEAD, bdle_pkg::MODE_ADD_TAIL: begin
				if (n >= CAP)
					st = bdle_pkg::ST_FULL;
				else if (r.mode == bdle_pkg::MODE_ADD_HEAD)
					list_mirror.push_front(r.item_value);
				else
					list_mirror.push_back(r.item_value);
			end
			bdle_pkg::MODE_DUMP, bdle_pkg::MODE_DUMP_REV: begin
				if (n == 0)
					st = bdle_pkg::ST_EMPTY;
				else begin
					for (int i = 0; i < n; i++)
						pending_rsp.push_back(mk(bdle_pkg::ST_DONE,
							list_mirror[r.mode == bdle_pkg::MODE_DUMP ? i : n - 1 - i],
							i == n - 1));
					return;
				end
			end
			bdle_pkg::MODE_SEARCH: begin
				if (n == 0)
					st = bdle_pkg::ST_EMPTY;
				else
					st = (hit >= 0) ? bdle_pkg::ST_FOUND : bdle_pkg::ST_NOT_FOUND;
			end
			bdle_pkg::MODE_DEL_HEAD, bdle_pkg::MODE_DEL_TAIL: begin
				if (n == 0)
					st = bdle_pkg::ST_EMPTY;
				else if (r.mode == bdle_pkg::MODE_DEL_HEAD)
					void'(list_mirror.pop_front());
				else
					void'(list_mirror.pop_back());
			end
			bdle_pkg::MODE_DEL_POS: begin
				if (r.position < 1 || r.position > n)
					st = bdle_pkg::ST_BAD_POS;
				else
					list_mirror.delete(r.position - 1);
			end
			bdle_pkg::MODE_DEL_VAL: begin
				if (n == 0)
					st = bdle_pkg::ST_EMPTY;
				else if (hit < 0)
					st = bdle_pkg::ST_NOT_FOUND;
				else
					list_mirror.delete(hit);
			end
			bdle_pkg::MODE_INS_POS: begin
				if (n >= CAP)
					st = bdle_pkg::ST_FULL;
				else if (r.position < 1 || r.position > n + 1)
					st = bdle_pkg::ST_BAD_POS;
				else
					list_mirror.insert(r.position - 1, r.item_value);
			end
			default: ;
		endcase
		pending_rsp.push_back(mk(st, 32'sd0, 1'b1));
	endtask

	task automatic send(input bdle_pkg::req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(r);
	endtask

	function automatic bdle_pkg::req_t mkreq(input logic [3:0] m,
			input logic signed [31:0] v, input logic [5:0] p);
		bdle_pkg::req_t r;
		r.mode = m;
		r.item_value = v;
		r.position = p;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 7));
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic row_t row(input bdle_pkg::req_t r, input bit t,
			input bdle_pkg::rsp_t w);
		row_t x;
		x.r = r;
		x.typed = t;
		x.want = w;
		return x;
	endfunction

	// Sender.
	initial begin
		bdle_pkg::rsp_t none;
		bdle_pkg::rsp_t emp;
		bdle_pkg::rsp_t bad;
		int n;
		none = mk(bdle_pkg::ST_DONE, 32'sd0, 1'b1);
		emp = mk(bdle_pkg::ST_EMPTY, 32'sd0, 1'b1);
		bad = mk(bdle_pkg::ST_BAD_POS, 32'sd0, 1'b1);
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(row(mkreq(bdle_pkg::MODE_DUMP, 32'sd0, 6'd0), 1'b1, emp));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DUMP_REV, 32'sd0, 6'd0), 1'b1, emp));
		directed.push_back(row(mkreq(bdle_pkg::MODE_SEARCH, 32'sd5, 6'd0), 1'b1, emp));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_HEAD, 32'sd0, 6'd0), 1'b1, emp));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_TAIL, 32'sd0, 6'd0), 1'b1, emp));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_VAL, 32'sd0, 6'd0), 1'b1, emp));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_POS, 32'sd0, 6'd1), 1'b1, bad));
		directed.push_back(row(mkreq(bdle_pkg::MODE_INS_POS, 32'sd1, 6'd0), 1'b1, bad));
		directed.push_back(row(mkreq(bdle_pkg::MODE_INS_POS, 32'sd1, 6'd2), 1'b1, bad));
		directed.push_back(row(mkreq(bdle_pkg::MODE_ADD_HEAD, 32'sh7fff_ffff, 6'd0),
			1'b1, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_ADD_TAIL, 32'sh8000_0000, 6'd0),
			1'b1, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_INS_POS, -32'sd1, 6'd2), 1'b1, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DUMP, 32'sd0, 6'd0), 1'b0, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DUMP_REV, 32'sd0, 6'd0), 1'b0, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_SEARCH, -32'sd1, 6'd0), 1'b1,
			mk(bdle_pkg::ST_FOUND, 32'sd0, 1'b1)));
		directed.push_back(row(mkreq(bdle_pkg::MODE_SEARCH, 32'sd3, 6'd0), 1'b1,
			mk(bdle_pkg::ST_NOT_FOUND, 32'sd0, 1'b1)));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_VAL, 32'sd3, 6'd0), 1'b1,
			mk(bdle_pkg::ST_NOT_FOUND, 32'sd0, 1'b1)));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_POS, 32'sd0, 6'd63), 1'b1, bad));
		directed.push_back(row(mkreq(4'd15, -32'sd1, 6'd63), 1'b1, none));
		directed.push_back(row(mkreq(4'd10, 32'sd0, 6'd0), 1'b1, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_VAL, -32'sd1, 6'd0), 1'b1, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_POS, 32'sd0, 6'd2), 1'b1, none));
		directed.push_back(row(mkreq(bdle_pkg::MODE_DEL_HEAD, 32'sd0, 6'd0), 1'b1, none));

		foreach (directed[i]) begin
			send(directed[i].r);
			if (directed[i].typed && pending_rsp[$] != directed[i].want)
				report($sformatf("directed row %0d: model disagrees with table", i));
		end

		// Fill to full, then hit the full checks, with a long output stall.
		hold_long = 1;
		for (int i = 0; i < CAP; i++)
			send(mkreq(bdle_pkg::MODE_ADD_TAIL, rand_value(), 6'd0));
		send(mkreq(bdle_pkg::MODE_ADD_HEAD, 32'sd1, 6'd0));
		send(mkreq(bdle_pkg::MODE_INS_POS, 32'sd1, 6'd1));
		send(mkreq(bdle_pkg::MODE_DUMP, 32'sd0, 6'd0));
		send(mkreq(bdle_pkg::MODE_DEL_POS, 32'sd0, 6'd32));
		send(mkreq(bdle_pkg::MODE_INS_POS, 32'sd7, 6'd32));
		send(mkreq(bdle_pkg::MODE_DUMP_REV, 32'sd0, 6'd0));

		for (int i = 0; i < 40; i++) begin
			logic [3:0] m;
			logic [5:0] p;
			logic signed [31:0] v;
			n = list_mirror.size();
			m = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, 9));
			if (n < 8 && $urandom_range(0, 1))
				m = ($urandom_range(0, 1)) ? bdle_pkg::MODE_ADD_HEAD : bdle_pkg::MODE_INS_POS;
			p = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, n + 1));
			v = rand_value();
			if (n > 0 && $urandom_range(0, 1))
				v = list_mirror[$urandom_range(0, n - 1)];
			send(mkreq(m, v, p));
		end
		req_ch.valid <= 1'b0;
		stim_done = 1;
	end

	// Receiver with random backpressure and one long hold.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				hold_long = 0;
				rsp_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
					: $urandom_range(0, 2);
				if ($urandom_range(0, 3) == 0)
					stall = 0;
				if (stall > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Output checker.
	always @(posedge clk) begin
		bdle_pkg::rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0)
				report("response with nothing expected");
			else begin
				want = pending_rsp.pop_front();
				if (rsp_ch.data.status !== want.status)
					report($sformatf("status %0d, expected %0d",
						rsp_ch.data.status, want.status));
				if (rsp_ch.data.element_value !== want.element_value)
					report($sformatf("element_value %0d, expected %0d",
						rsp_ch.data.element_value, want.element_value));
				if (rsp_ch.data.last !== want.last)
					report($sformatf("last %0b, expected %0b",
						rsp_ch.data.last, want.last));
			end
		end
	end

	initial begin
		int waited;
		waited = 0;
		wait (stim_done);
		while (pending_rsp.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_rsp.size() != 0)
			report("responses still expected at the end");
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("bounded_double_ended_list_engine_core_tb: clean");
		else
			$display("bounded_double_ended_list_engine_core_tb: errors");
		$finish;
	end
endmodule
